// ===== rtl/smoothed_led_bar_graph_defines.svh =====
// ----------------------------------------------------------------------------
// Smoothed LED bar graph assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_LED_BAR_GRAPH_DEFINES_SVH
`define SMOOTHED_LED_BAR_GRAPH_DEFINES_SVH
`ifndef SYNTHESIS
`define SLED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoothed_led_bar_graph: same-cycle check failed");
`define SLED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoothed_led_bar_graph: next-cycle check failed");
`else
`define SLED_ASSERT_SAME(label, ante, cons)
`define SLED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/sled_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed LED bar graph package
// Widths, constants, command and status types and LED scaling helpers.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int ROW_COUNT    = 2;
    localparam int LEDS_PER_ROW = 8;
    localparam int ROW_W        = 1;
    localparam int LEVEL_W      = 17;
    localparam int THR_W        = 16;
    localparam int LED_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 17;
    localparam int PROD_W       = 2 * LEVEL_W;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = LEDS_PER_ROW * LED_W;
    localparam int FULL_INT     = 65536;
    localparam int BUCKET_SIZE  = FULL_INT / LEDS_PER_ROW;
    localparam int BUCKET_W     = $clog2(BUCKET_SIZE) + 1;
    localparam int SCALE_W      = BUCKET_W + LED_W;
    localparam int SHIFT        = $clog2(BUCKET_SIZE);

    localparam logic [LEVEL_W-1:0] FULL_SCALE      = LEVEL_W'(FULL_INT);
    localparam logic [PROD_W-1:0]  ROUND_HALF      = PROD_W'(FULL_INT / 2);
    localparam logic [LEVEL_W-1:0] RESET_RATE      = LEVEL_W'(3277);
    localparam logic [THR_W-1:0]   RESET_THRESHOLD = THR_W'(66);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING_RATE   = 1'b0,
        CFG_CHANGE_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic load_in;
        logic load_direct;
        logic mul_first;
        logic mul_second;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic row_ok;
        logic loaded;
        logic small_change;
        logic out_free;
    } sts_t;

    function automatic logic [LEVEL_W-1:0] sat_full(input logic [LEVEL_W:0] v);
        logic [LEVEL_W-1:0] r;
        if (v > {1'b0, FULL_SCALE}) begin
            r = FULL_SCALE;
        end else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [LED_W-1:0] led_byte(input logic [LEVEL_W-1:0] level,
                                                  input int bucket);
        logic [LEVEL_W-1:0] base;
        logic [LEVEL_W-1:0] over;
        logic [BUCKET_W-1:0] p;
        logic [SCALE_W-1:0] scaled;
        base = LEVEL_W'(bucket * BUCKET_SIZE);
        if (level <= base) begin
            p = '0;
        end else begin
            over = level - base;
            if (over > LEVEL_W'(BUCKET_SIZE)) begin
                p = BUCKET_W'(BUCKET_SIZE);
            end else begin
                p = over[BUCKET_W-1:0];
            end
        end
        scaled = (SCALE_W'(p) << LED_W) - SCALE_W'(p) + SCALE_W'(BUCKET_SIZE / 2);
        return scaled[SHIFT +: LED_W];
    endfunction

endpackage

// ===== rtl/smoothed_led_bar_graph.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed LED bar graph
// Per-row exponential moving average of usage samples, shown as eight LEDs.
// ----------------------------------------------------------------------------
// An EMA update passes through check, two sequential multiply steps and emit,
// and no new item is taken until the FSM is back in idle; m_tvalid is registered
// from emit. A first sample skips the multiplies; a change below threshold stops at check.
// A finished result waits in the output register while the next item is taken.
// Reset clears all loaded flags, the FSM and the output valid, and restores
// the smoothing rate to 3277 and the change threshold to 66.
`include "smoothed_led_bar_graph_defines.svh"

module smoothed_led_bar_graph (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sled_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // usage_sample [16:0], zero fill [23:17]
    input  logic [sled_pkg::IN_DATA_W-1:0]  s_tdata,
    // row_index [0]
    input  logic [sled_pkg::ROW_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // led_level_0 [7:0] up to led_level_7 [63:56]
    output logic [sled_pkg::OUT_DATA_W-1:0] m_tdata,
    // out_row [0]
    output logic [sled_pkg::ROW_W-1:0]      m_tuser
);

    sled_pkg::cmd_t cmd;
    sled_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    sled_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sled_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    `SLED_ASSERT_SAME(a_no_overwrite, m_tvalid && !m_tready, !cmd.emit)
    `SLED_ASSERT_NEXT(a_emit_shows, cmd.emit, m_tvalid)
    `SLED_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && sts.row_ok, !s_tready)

endmodule

// ===== rtl/sled_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed LED bar graph controller
// Sequences accept, threshold check, two multiply steps and result hand-off.
// ----------------------------------------------------------------------------
module sled_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sled_pkg::sts_t sts,
    output sled_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid && sts.row_ok)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.loaded)
                begin
                    cmd.load_direct = 1'b1;
                    state_next      = ST_EMIT;
                end
                else if (sts.small_change)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_first = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sled_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed LED bar graph datapath
// Configuration, per-row level store, EMA multiplier steps and output register.
// ----------------------------------------------------------------------------
module sled_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [sled_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sled_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [sled_pkg::ROW_W-1:0]          s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [sled_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [sled_pkg::ROW_W-1:0]          m_tuser,
    input  sled_pkg::cmd_t                      cmd,
    output sled_pkg::sts_t                      sts
);

    logic [sled_pkg::LEVEL_W-1:0]    rate_reg;
    logic [sled_pkg::THR_W-1:0]      thr_reg;
    logic [sled_pkg::LEVEL_W-1:0]    level_mem_reg [sled_pkg::ROW_COUNT];
    logic                            loaded_mem_reg [sled_pkg::ROW_COUNT];
    logic [sled_pkg::ROW_W-1:0]      row_reg;
    logic [sled_pkg::LEVEL_W-1:0]    u_reg;
    logic [sled_pkg::LEVEL_W-1:0]    a_reg;
    logic [sled_pkg::LEVEL_W-1:0]    s_reg;
    logic [sled_pkg::LEVEL_W-1:0]    s_next;
    logic                            cur_loaded_reg;
    logic [sled_pkg::PROD_W-1:0]     prod_reg;
    logic [sled_pkg::PROD_W-1:0]     acc;
    logic [sled_pkg::LEVEL_W-1:0]    diff;
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [sled_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [sled_pkg::OUT_DATA_W-1:0] m_tdata_next;
    logic [sled_pkg::ROW_W-1:0]      m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= sled_pkg::RESET_RATE;
            thr_reg  <= sled_pkg::RESET_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            unique case (sled_pkg::cfg_index_t'(cfg_index))
                sled_pkg::CFG_SMOOTHING_RATE:   rate_reg <= cfg_data;
                sled_pkg::CFG_CHANGE_THRESHOLD: thr_reg  <= cfg_data[sled_pkg::THR_W-1:0];
                default:                        rate_reg <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        acc  = prod_reg
             + sled_pkg::PROD_W'(sled_pkg::FULL_SCALE - a_reg) * sled_pkg::PROD_W'(s_reg)
             + sled_pkg::ROUND_HALF;
        diff = (u_reg > s_reg) ? (u_reg - s_reg) : (s_reg - u_reg);
        s_next = s_reg;
        if (cmd.load_direct)
        begin
            s_next = u_reg;
        end
        else if (cmd.mul_second)
        begin
            s_next = sled_pkg::sat_full(acc[sled_pkg::LEVEL_W + 16 : 16]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            row_reg        <= s_tuser;
            u_reg          <= sled_pkg::sat_full({1'b0, s_tdata[sled_pkg::LEVEL_W-1:0]});
            a_reg          <= sled_pkg::sat_full({1'b0, rate_reg});
            s_reg          <= level_mem_reg[s_tuser];
            cur_loaded_reg <= loaded_mem_reg[s_tuser];
        end
        else
        begin
            s_reg <= s_next;
        end
        if (cmd.mul_first)
        begin
            prod_reg <= sled_pkg::PROD_W'(a_reg) * sled_pkg::PROD_W'(u_reg);
        end
        if (cmd.load_direct || cmd.mul_second)
        begin
            level_mem_reg[row_reg] <= s_next;
        end
        if (cmd.emit)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < sled_pkg::ROW_COUNT; r++)
            begin
                loaded_mem_reg[r] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_direct)
            begin
                loaded_mem_reg[row_reg] <= 1'b1;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < sled_pkg::LEDS_PER_ROW; i++)
        begin
            m_tdata_next[i*sled_pkg::LED_W +: sled_pkg::LED_W] = sled_pkg::led_byte(s_reg, i);
        end
        if (cmd.emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_comb
    begin
        sts.row_ok       = (int'(s_tuser) < sled_pkg::ROW_COUNT);
        sts.loaded       = cur_loaded_reg;
        sts.small_change = (diff < {1'b0, thr_reg});
        sts.out_free     = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== verif/tb_smoothed_led_bar_graph.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed LED bar graph testbench
// Drives usage samples into the bar graph block and checks every LED frame
// against a per-row moving-average model kept in the testbench. Directed
// cases cover the first sample of a row, the change threshold, saturation
// and bucket edges. Random phases then sweep the register settings with
// random gaps on either side in most phases, and one phase holds off the
// output for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_smoothed_led_bar_graph;

    import sled_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int SAMPLE_MAX     = 131071;

    typedef struct packed {
        logic [ROW_W-1:0]                   row;
        logic [LEDS_PER_ROW-1:0][LED_W-1:0] leds;
    } led_frame_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [ROW_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ROW_W-1:0]      m_tuser;

    logic [CFG_DATA_W-1:0] rate_reg;
    logic [THR_W-1:0]      threshold_reg;
    logic [LEVEL_W-1:0]    row_level [ROW_COUNT];
    logic                  row_loaded [ROW_COUNT];
    led_frame_t            pending_frames [$];

    int  mismatch_count;
    int  idle_cycles;
    int  rx_hold_cycles;
    bit  tx_idle_en;
    bit  rx_stall_en;

    smoothed_led_bar_graph dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [LEVEL_W-1:0] clip_to_full(input logic [63:0] v);
        logic [LEVEL_W-1:0] r;
        if (v > 64'(FULL_INT))
        begin
            r = LEVEL_W'(FULL_INT);
        end
        else
        begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

    function automatic led_frame_t bar_frame(input logic [ROW_W-1:0] row,
                                             input logic [LEVEL_W-1:0] level);
        led_frame_t f;
        int         part;
        f.row = row;
        for (int i = 0; i < LEDS_PER_ROW; i++)
        begin
            part = int'(level) - i * BUCKET_SIZE;
            if (part < 0)
            begin
                part = 0;
            end
            if (part > BUCKET_SIZE)
            begin
                part = BUCKET_SIZE;
            end
            f.leds[i] = LED_W'((part * 255 + BUCKET_SIZE / 2) / BUCKET_SIZE);
        end
        return f;
    endfunction

    function automatic void track_sample(input logic [ROW_W-1:0] row,
                                         input logic [LEVEL_W-1:0] raw);
        logic [LEVEL_W-1:0] u;
        logic [LEVEL_W-1:0] a;
        logic [LEVEL_W-1:0] s;
        logic [LEVEL_W-1:0] diff;
        logic [63:0]        acc;
        u = clip_to_full(64'(raw));
        a = clip_to_full(64'(rate_reg));
        s = row_level[row];
        if (row_loaded[row])
        begin
            diff = (u > s) ? (u - s) : (s - u);
            if (diff < LEVEL_W'(threshold_reg))
            begin
                return;
            end
            acc = 64'(a) * 64'(u) + 64'(FULL_INT - int'(a)) * 64'(s) + 64'(FULL_INT / 2);
            s = clip_to_full(acc >> 16);
        end
        else
        begin
            s = u;
            row_loaded[row] = 1'b1;
        end
        row_level[row] = s;
        pending_frames.push_back(bar_frame(row, s));
    endfunction

    function automatic int pick_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            gap = 0;
        end
        else if (roll < 88)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            gap = $urandom_range(4, 10);
        end
        else
        begin
            gap = $urandom_range(20, 40);
        end
        return gap;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_sample(input logic [ROW_W-1:0] row);
        int u;
        int delta;
        case ($urandom_range(0, 9))
            0: u = $urandom_range(0, SAMPLE_MAX);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: u = 0;
                    1: u = FULL_INT;
                    2: u = FULL_INT - 1;
                    default: u = SAMPLE_MAX;
                endcase
            end
            2, 3, 4: u = $urandom_range(0, FULL_INT);
            default:
            begin
                delta = $urandom_range(0, 2 * int'(threshold_reg) + 16);
                u = int'(row_level[row]) + ($urandom_range(0, 1) ? delta : -delta);
                if (u < 0)
                begin
                    u = 0;
                end
                if (u > FULL_INT)
                begin
                    u = FULL_INT;
                end
            end
        endcase
        return LEVEL_W'(u);
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch on %s: expected %0d, actual %0d", $realtime, what, want, got);
        end
    endtask

    task automatic send_sample(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] u);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(u);
        s_tuser  <= row;
        do
            @(posedge clk);
        while (!s_tready);
        track_sample(row, u);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SMOOTHING_RATE)
        begin
            rate_reg = value;
        end
        else
        begin
            threshold_reg = value[THR_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] rate,
                             input logic [THR_W-1:0] threshold);
        wait_drained();
        write_register(CFG_SMOOTHING_RATE, rate);
        write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(threshold));
    endtask

    task automatic test_directed_samples();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_sample(1'b0, 17'd0);
        send_sample(1'b1, 17'd131071);
        send_sample(1'b0, 17'd65);
        send_sample(1'b0, 17'd66);
        send_sample(1'b1, 17'd65471);
        send_sample(1'b1, 17'd65470);
        send_sample(1'b0, 17'd65536);
        send_sample(1'b0, 17'd65537);
        send_sample(1'b1, 17'd0);
        send_sample(1'b0, 17'd12345);
    endtask

    task automatic test_config_extremes();
        configure(17'd65536, 16'd0);
        send_sample(1'b0, 17'd8192);
        send_sample(1'b0, 17'd8192);
        send_sample(1'b0, 17'd8193);
        send_sample(1'b1, 17'd4095);
        send_sample(1'b1, 17'd4096);
        send_sample(1'b1, 17'd57344);
        send_sample(1'b0, 17'd0);
        configure(17'd0, 16'd65535);
        send_sample(1'b0, 17'd131071);
        send_sample(1'b0, 17'd65534);
        send_sample(1'b1, 17'd0);
        configure(17'd131071, 16'd1);
        send_sample(1'b1, 17'd65536);
        send_sample(1'b1, 17'd65536);
        configure(17'd65537, 16'd66);
        send_sample(1'b0, 17'd40000);
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] rate;
        logic [THR_W-1:0]      threshold;
        logic [ROW_W-1:0]      row;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: rate = 17'd3277;
                1: rate = 17'd65536;
                2: rate = 17'd1;
                3: rate = 17'd131071;
                4: rate = 17'd65535;
                default: rate = CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
            endcase
            case ($urandom_range(0, 3))
                0: threshold = 16'd0;
                1: threshold = THR_W'($urandom_range(0, 200));
                2: threshold = THR_W'($urandom_range(0, 2000));
                default: threshold = 16'd1;
            endcase
            configure(rate, threshold);
            tx_idle_en  = (phase % 3) != 0;
            rx_stall_en = (phase % 2) != 0;
            for (int n = 0; n < 230; n++)
            begin
                row = ROW_W'($urandom_range(0, ROW_COUNT - 1));
                send_sample(row, pick_sample(row));
            end
        end
    endtask

    task automatic test_backpressure();
        configure(17'd20000, 16'd0);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        repeat (8) @(posedge clk);
        rx_hold_cycles = 300;
        for (int n = 0; n < 40; n++)
        begin
            send_sample(ROW_W'(n % 2), LEVEL_W'($urandom_range(0, FULL_INT)));
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        for (int n = 0; n < 60; n++)
        begin
            send_sample(ROW_W'(n % 2), LEVEL_W'($urandom_range(0, SAMPLE_MAX)));
        end
    endtask

    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
            end
            else if (rx_stall_en && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap() + 1;
                m_tready <= 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 6);
                m_tready <= 1'b1;
            end
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        led_frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_frames.size() == 0)
            begin
                note_mismatch("unexpected transaction, row", 0, m_tuser);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (m_tuser !== want.row)
                begin
                    note_mismatch("out_row", want.row, m_tuser);
                end
                for (int i = 0; i < LEDS_PER_ROW; i++)
                begin
                    if (m_tdata[i*LED_W +: LED_W] !== want.leds[i])
                    begin
                        note_mismatch($sformatf("led_level_%0d", i), want.leds[i],
                                      m_tdata[i*LED_W +: LED_W]);
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SMOOTHING_RATE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        mismatch_count = 0;
        rx_hold_cycles = 0;
        tx_idle_en     = 1'b0;
        rx_stall_en    = 1'b0;
        rate_reg       = CFG_DATA_W'(RESET_RATE);
        threshold_reg  = RESET_THRESHOLD;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            row_level[r]  = '0;
            row_loaded[r] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_samples();
        test_config_extremes();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            note_mismatch("frames never delivered", 0, pending_frames.size());
        end
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
